FILE: rtl/lpkim_pkg.sv
`default_nettype none
package lpkim_pkg;

  localparam int TBL_DEPTH = 1024;
  localparam int TBL_AW = $clog2(TBL_DEPTH);
  localparam int IDX_DEPTH = 1024;
  localparam int IDX_AW = $clog2(IDX_DEPTH);
  localparam int KEY_BYTES = 8;
  localparam int KEY_W = 64;
  localparam int IDX_W = 10;
  localparam int LIVE_W = 11;
  localparam int LIM_W = 10;
  localparam logic [LIM_W-1:0] LIM_RESET = 10'd716;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] HASH_MUL = 64'h00000100000001B3;

  localparam logic [1:0] F_SET = 2'd0;
  localparam logic [1:0] F_GET = 2'd1;
  localparam logic [1:0] F_REMOVE = 2'd2;
  localparam logic [1:0] F_REVERSE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [TBL_AW-1:0]  pos;
    logic [IDX_W-1:0]   idx;
  } slot_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } rev_t;

endpackage
`default_nettype wire

FILE: rtl/lpkim_if.sv
`default_nettype none
interface lpkim_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [63:0] key;
  logic [9:0] index;
  modport source (output valid, func, key, index, input ready);
  modport sink (input valid, func, key, index, output ready);
endinterface

interface lpkim_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [9:0]  index_out;
  logic [63:0] key_out;
  logic [10:0] live_entries;
  modport source (output valid, status, found, index_out, key_out, live_entries, input ready);
  modport sink (input valid, status, found, index_out, key_out, live_entries, output ready);
endinterface
`default_nettype wire

FILE: rtl/linear_probe_key_index_map.sv
`default_nettype none
// After reset a clearing pass runs over both memories, during which no beat is accepted.
// Per beat: a reverse lookup reads the reverse memory and loads the result; set, get and
// remove hash the key byte-serially, then probe slot by slot, then write a new key, an
// update or a remove, which re-places each following cluster entry by a fresh probe.
// One operation at a time: no new beat is accepted until the result is loaded.
// Reset: asynchronous, active low; clears control state and live count, load_limit to 716.
module linear_probe_key_index_map (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lpkim_req_if.sink              req_i,
  lpkim_rsp_if.source            rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int TAW = lpkim_pkg::TBL_AW;
  localparam int IAW = lpkim_pkg::IDX_AW;
  localparam int CLR_DEPTH = (lpkim_pkg::TBL_DEPTH > lpkim_pkg::IDX_DEPTH) ?
                             lpkim_pkg::TBL_DEPTH : lpkim_pkg::IDX_DEPTH;
  localparam int CLR_W = $clog2(CLR_DEPTH + 1);
  localparam int PC_W = $clog2(lpkim_pkg::TBL_DEPTH + 1);
  localparam int LW = lpkim_pkg::LIVE_W;

  // Sequencer states.
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_PRB_RD = 4'd3;
  localparam logic [3:0] S_PRB_CK = 4'd4;
  localparam logic [3:0] S_RV_CK  = 4'd5;
  localparam logic [3:0] S_WR_REV = 4'd6;
  localparam logic [3:0] S_CL_RD  = 4'd7;
  localparam logic [3:0] S_CL_CK  = 4'd8;
  localparam logic [3:0] S_RL_CK  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  // Configuration register: register 0 sits at byte address 0.
  logic [lpkim_pkg::LIM_W-1:0] lim_q;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(lim_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= lpkim_pkg::LIM_RESET;
    end else if (cfg_wr) begin
      lim_q <= pwdata[lpkim_pkg::LIM_W-1:0];
    end
  end

  // Slot memory holds used bit, canonical key, home position and stored index.
  lpkim_pkg::slot_t slot_mem [lpkim_pkg::TBL_DEPTH];
  lpkim_pkg::slot_t srd_q, sw_data;
  logic             sw_en;
  logic [TAW-1:0]   sw_addr, sr_addr;

  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      slot_mem[sw_addr] <= sw_data;
    end
    srd_q <= slot_mem[sr_addr];
  end

  // Reverse memory maps an index back to its key.
  lpkim_pkg::rev_t rev_mem [lpkim_pkg::IDX_DEPTH];
  lpkim_pkg::rev_t rrd_q, rw_data;
  logic            rw_en;
  logic [IAW-1:0]  rw_addr, rr_addr;

  always_ff @(posedge clk_i) begin
    if (rw_en) begin
      rev_mem[rw_addr] <= rw_data;
    end
    rrd_q <= rev_mem[rr_addr];
  end

  // Hash unit.
  logic        hs_start, hs_done;
  logic [63:0] hs_hash, hs_canon;

  lpkim_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hs_start),
    .key_i   (req_i.key),
    .done_o  (hs_done),
    .hash_o  (hs_hash),
    .canon_o (hs_canon)
  );

  // Sequencer registers.
  logic [3:0]       state_q, state_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic             mv_q, mv_d;
  logic [LW-1:0]    live_q, live_d;
  logic [PC_W-1:0]  pcnt_q, pcnt_d;
  logic [PC_W-1:0]  cn_q, cn_d;
  logic [TAW-1:0]   p_q, p_d;
  logic [TAW-1:0]   hpos_q, hpos_d;
  logic [TAW-1:0]   cp_q, cp_d;
  logic [63:0]      pk_q, pk_d;
  logic [lpkim_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [lpkim_pkg::IDX_W-1:0] oidx_q, oidx_d;
  logic [1:0]       func_q, func_d;
  logic [1:0]       res_st_q, res_st_d;
  logic             res_fd_q, res_fd_d;
  logic [lpkim_pkg::IDX_W-1:0] res_ix_q, res_ix_d;
  logic [63:0]      res_key_q, res_key_d;

  // Output register.
  logic             out_vld_q;
  logic [1:0]       out_st_q;
  logic             out_fd_q;
  logic [lpkim_pkg::IDX_W-1:0] out_ix_q;
  logic [63:0]      out_key_q;
  logic [LW-1:0]    out_live_q;
  logic             out_load;

  logic [LW:0]      lim_eff;
  logic             idx_in_rng, oidx_in_rng;

  assign lim_eff = (lim_q > lpkim_pkg::LIM_W'(lpkim_pkg::TBL_DEPTH - 1)) ?
                   (LW+1)'(lpkim_pkg::TBL_DEPTH - 1) : (LW+1)'(lim_q);
  assign idx_in_rng = 32'(idx_q) < 32'(lpkim_pkg::IDX_DEPTH);
  assign oidx_in_rng = 32'(oidx_q) < 32'(lpkim_pkg::IDX_DEPTH);

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    mv_d = mv_q;
    live_d = live_q;
    pcnt_d = pcnt_q;
    cn_d = cn_q;
    p_d = p_q;
    hpos_d = hpos_q;
    cp_d = cp_q;
    pk_d = pk_q;
    idx_d = idx_q;
    oidx_d = oidx_q;
    func_d = func_q;
    res_st_d = res_st_q;
    res_fd_d = res_fd_q;
    res_ix_d = res_ix_q;
    res_key_d = res_key_q;
    hs_start = 1'b0;
    sw_en = 1'b0;
    sw_addr = p_q;
    sw_data = '{used: 1'b1, key: pk_q, pos: hpos_q, idx: idx_q};
    sr_addr = p_q;
    rw_en = 1'b0;
    rw_addr = idx_q[IAW-1:0];
    rw_data = '{valid: 1'b1, key: pk_q};
    rr_addr = idx_q[IAW-1:0];

    case (state_q)
      S_CLR: begin
        sw_en = clr_q < CLR_W'(lpkim_pkg::TBL_DEPTH);
        sw_addr = clr_q[TAW-1:0];
        sw_data = '0;
        rw_en = clr_q < CLR_W'(lpkim_pkg::IDX_DEPTH);
        rw_addr = clr_q[IAW-1:0];
        rw_data = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        rr_addr = req_i.index[IAW-1:0];
        if (req_i.valid) begin
          func_d = req_i.func;
          idx_d = req_i.index;
          res_st_d = lpkim_pkg::ST_OK;
          res_fd_d = 1'b0;
          res_ix_d = '0;
          res_key_d = '0;
          mv_d = 1'b0;
          if (req_i.func == lpkim_pkg::F_REVERSE) begin
            state_d = S_RL_CK;
          end else begin
            hs_start = 1'b1;
            state_d = S_HASH;
          end
        end
      end
      S_RL_CK: begin
        if (idx_in_rng && rrd_q.valid) begin
          res_fd_d = 1'b1;
          res_key_d = rrd_q.key;
        end else begin
          res_st_d = lpkim_pkg::ST_NOT_FOUND;
        end
        state_d = S_DONE;
      end
      S_HASH: begin
        if (hs_done) begin
          pk_d = hs_canon;
          hpos_d = hs_hash[TAW-1:0];
          p_d = hs_hash[TAW-1:0];
          pcnt_d = '0;
          state_d = S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        state_d = S_PRB_CK;
      end
      S_PRB_CK: begin
        if (srd_q.used && (srd_q.key != pk_q)) begin
          // Occupied by another key: step to the next slot.
          if (pcnt_q == PC_W'(lpkim_pkg::TBL_DEPTH - 1)) begin
            if (mv_q) begin
              cp_d = cp_q + 1'b1;
              cn_d = cn_q + 1'b1;
              state_d = S_CL_RD;
            end else begin
              res_st_d = (func_q == lpkim_pkg::F_SET) ? lpkim_pkg::ST_FULL :
                         lpkim_pkg::ST_NOT_FOUND;
              state_d = S_DONE;
            end
          end else begin
            p_d = p_q + 1'b1;
            pcnt_d = pcnt_q + 1'b1;
            state_d = S_PRB_RD;
          end
        end else if (mv_q) begin
          // Re-place the entry taken out of the cluster.
          sw_en = 1'b1;
          cp_d = cp_q + 1'b1;
          cn_d = cn_q + 1'b1;
          state_d = S_CL_RD;
        end else begin
          res_fd_d = srd_q.used;
          oidx_d = srd_q.idx;
          rr_addr = srd_q.idx[IAW-1:0];
          case (func_q)
            lpkim_pkg::F_GET: begin
              if (srd_q.used) begin
                res_ix_d = srd_q.idx;
              end else begin
                res_st_d = lpkim_pkg::ST_NOT_FOUND;
              end
              state_d = S_DONE;
            end
            lpkim_pkg::F_SET: begin
              if (srd_q.used) begin
                sw_en = 1'b1;
                state_d = S_RV_CK;
              end else if (({1'b0, live_q} + 1'b1) > lim_eff) begin
                res_st_d = lpkim_pkg::ST_FULL;
                state_d = S_DONE;
              end else begin
                sw_en = 1'b1;
                live_d = live_q + 1'b1;
                state_d = S_WR_REV;
              end
            end
            default: begin
              if (srd_q.used) begin
                sw_en = 1'b1;
                sw_data = '0;
                live_d = live_q - 1'b1;
                cp_d = p_q + 1'b1;
                cn_d = '0;
                state_d = S_RV_CK;
              end else begin
                res_st_d = lpkim_pkg::ST_NOT_FOUND;
                state_d = S_DONE;
              end
            end
          endcase
        end
      end
      S_RV_CK: begin
        // Drop the reverse entry of the old index only if it still names this key.
        rw_addr = oidx_q[IAW-1:0];
        rw_data = '{valid: 1'b0, key: pk_q};
        rw_en = oidx_in_rng && rrd_q.valid && (rrd_q.key == pk_q);
        state_d = (func_q == lpkim_pkg::F_SET) ? S_WR_REV : S_CL_RD;
      end
      S_WR_REV: begin
        rw_en = idx_in_rng;
        state_d = S_DONE;
      end
      S_CL_RD: begin
        sr_addr = cp_q;
        if (cn_q == PC_W'(lpkim_pkg::TBL_DEPTH)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CL_CK;
        end
      end
      S_CL_CK: begin
        if (!srd_q.used) begin
          state_d = S_DONE;
        end else begin
          // Take the entry out and probe for its new place from its home slot.
          sw_en = 1'b1;
          sw_addr = cp_q;
          sw_data = '0;
          mv_d = 1'b1;
          pk_d = srd_q.key;
          hpos_d = srd_q.pos;
          idx_d = srd_q.idx;
          p_d = srd_q.pos;
          pcnt_d = '0;
          state_d = S_PRB_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      mv_q <= 1'b0;
      live_q <= '0;
      pcnt_q <= '0;
      cn_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      mv_q <= mv_d;
      live_q <= live_d;
      pcnt_q <= pcnt_d;
      cn_q <= cn_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    hpos_q <= hpos_d;
    cp_q <= cp_d;
    pk_q <= pk_d;
    idx_q <= idx_d;
    oidx_q <= oidx_d;
    func_q <= func_d;
    res_st_q <= res_st_d;
    res_fd_q <= res_fd_d;
    res_ix_q <= res_ix_d;
    res_key_q <= res_key_d;
    if (out_load) begin
      out_st_q <= res_st_q;
      out_fd_q <= res_fd_q;
      out_ix_q <= res_ix_q;
      out_key_q <= res_key_q;
      out_live_q <= live_q;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.status = out_st_q;
  assign rsp_o.found = out_fd_q;
  assign rsp_o.index_out = out_ix_q;
  assign rsp_o.key_out = out_key_q;
  assign rsp_o.live_entries = out_live_q;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= LW'(lpkim_pkg::TBL_DEPTH - 1))
    else $error("live count above table capacity");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !req_i.ready)
    else $error("beat accepted during clearing pass");

  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_done |-> state_q == S_HASH)
    else $error("hash finished outside hash state");
`endif

endmodule
`default_nettype wire

FILE: rtl/lpkim_hash.sv
`default_nettype none
// Byte-serial FNV-1a: one key byte per cycle; bytes from the first zero byte on are ignored.
module lpkim_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] key_i,
  output logic             done_o,
  output logic [63:0]      hash_o,
  output logic [63:0]      canon_o
);

  localparam int CNT_W = 4;

  logic             run_q, done_q, alive_q;
  logic [CNT_W-1:0] cnt_q;
  logic [63:0]      sh_q, h_q, canon_q;
  logic [7:0]       cur_byte;
  logic             take;
  logic [63:0]      x, prod;

  assign cur_byte = sh_q[7:0];
  assign take = alive_q && (cur_byte != 8'd0);
  assign x = h_q ^ {56'd0, cur_byte};

  // The prime has few set bits, so the product is a short sum of shifts.
  always_comb begin
    prod = '0;
    for (int i = 0; i < 64; i++) begin
      if (lpkim_pkg::HASH_MUL[i]) begin
        prod = prod + (x << i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      alive_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        alive_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (!take) begin
          alive_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(lpkim_pkg::KEY_BYTES - 1)) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= key_i;
      h_q <= lpkim_pkg::FNV_BASIS;
      canon_q <= '0;
    end else if (run_q) begin
      sh_q <= sh_q >> 8;
      if (take) begin
        h_q <= prod;
        canon_q[8*cnt_q[2:0] +: 8] <= cur_byte;
      end
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q;
  assign canon_o = canon_q;

endmodule
`default_nettype wire

FILE: sim/tb_channels.sv
`timescale 1ns / 1ps
// The block's own interfaces (lpkim_req_if, lpkim_rsp_if) are compiled from rtl.
// This file holds a small helper interface for the configuration bus.
interface tb_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  modport source (output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
  modport sink (input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

FILE: sim/map_checker.sv
`timescale 1ns / 1ps
module map_checker
  import lpkim_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [1:0]  req_func_i,
  input  logic [63:0] req_key_i,
  input  logic [9:0]  req_index_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [1:0]  rsp_status_i,
  input  logic        rsp_found_i,
  input  logic [9:0]  rsp_index_i,
  input  logic [63:0] rsp_key_i,
  input  logic [10:0] rsp_live_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [9:0]  index_out;
    logic [63:0] key_out;
    logic [10:0] live;
  } answer_t;

  // Shadow copy of the table.
  logic [63:0] tbl_key [TBL_DEPTH];
  logic [63:0] tbl_hash[TBL_DEPTH];
  logic [9:0]  tbl_idx [TBL_DEPTH];
  logic        tbl_used[TBL_DEPTH];
  logic [63:0] rev_key [IDX_DEPTH];
  logic        rev_ok  [IDX_DEPTH];
  int          live_cnt;
  int          limit;
  answer_t     answers_due[$];

  assign pending_o = answers_due.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  function automatic logic [63:0] fnv_cut(input logic [63:0] raw, output logic [63:0] cut);
    logic [63:0] h;
    logic        stop;
    h = FNV_BASIS;
    cut = '0;
    stop = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'd0) stop = 1'b1;
      if (!stop) begin
        cut[8*b +: 8] = raw[8*b +: 8];
        h = (h ^ {56'd0, raw[8*b +: 8]}) * HASH_MUL;
      end
    end
    return h;
  endfunction

  // Returns 1 on a hit, 0 on an empty slot, -1 when every slot is taken.
  function automatic int seek(input logic [63:0] k, input logic [63:0] h, output int slot);
    int p;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      p = (int'(h[TBL_AW-1:0]) + i) % TBL_DEPTH;
      if (!tbl_used[p]) begin
        slot = p;
        return 0;
      end
      if (tbl_hash[p] == h && tbl_key[p] == k) begin
        slot = p;
        return 1;
      end
    end
    slot = 0;
    return -1;
  endfunction

  function automatic answer_t apply_op(input logic [1:0] fn, input logic [63:0] raw,
                                       input logic [9:0] idx);
    answer_t a;
    logic [63:0] k, h, mk, mh;
    logic [9:0] mi;
    int r, slot, p, dst, cap;
    a = '0;
    h = fnv_cut(raw, k);
    if (fn == F_REVERSE) begin
      if (rev_ok[idx]) begin
        a.found = 1'b1;
        a.key_out = rev_key[idx];
      end else begin
        a.status = ST_NOT_FOUND;
      end
    end else begin
      r = seek(k, h, slot);
      a.found = (r == 1);
      case (fn)
        F_SET: begin
          if (r == 1) begin
            if (rev_ok[tbl_idx[slot]] && rev_key[tbl_idx[slot]] == k)
              rev_ok[tbl_idx[slot]] = 1'b0;
            tbl_idx[slot] = idx;
            rev_key[idx] = k;
            rev_ok[idx] = 1'b1;
          end else begin
            cap = (limit > TBL_DEPTH - 1) ? TBL_DEPTH - 1 : limit;
            if (r < 0 || live_cnt + 1 > cap) begin
              a.status = ST_FULL;
            end else begin
              tbl_key[slot] = k;
              tbl_hash[slot] = h;
              tbl_idx[slot] = idx;
              tbl_used[slot] = 1'b1;
              live_cnt++;
              rev_key[idx] = k;
              rev_ok[idx] = 1'b1;
            end
          end
        end
        F_GET: begin
          if (r == 1) a.index_out = tbl_idx[slot];
          else a.status = ST_NOT_FOUND;
        end
        default: begin
          if (r != 1) begin
            a.status = ST_NOT_FOUND;
          end else begin
            if (rev_ok[tbl_idx[slot]] && rev_key[tbl_idx[slot]] == k)
              rev_ok[tbl_idx[slot]] = 1'b0;
            tbl_used[slot] = 1'b0;
            live_cnt--;
            // Re-place the rest of the cluster; reverse entries stay put.
            p = (slot + 1) % TBL_DEPTH;
            for (int n = 0; n < TBL_DEPTH && tbl_used[p]; n++) begin
              mk = tbl_key[p];
              mh = tbl_hash[p];
              mi = tbl_idx[p];
              tbl_used[p] = 1'b0;
              if (seek(mk, mh, dst) >= 0) begin
                tbl_key[dst] = mk;
                tbl_hash[dst] = mh;
                tbl_idx[dst] = mi;
                tbl_used[dst] = 1'b1;
              end
              p = (p + 1) % TBL_DEPTH;
            end
          end
        end
      endcase
    end
    a.live = live_cnt[10:0];
    return a;
  endfunction

  initial begin
    errors_o = 0;
    live_cnt = 0;
    limit = int'(LIM_RESET);
    for (int i = 0; i < TBL_DEPTH; i++) tbl_used[i] = 1'b0;
    for (int i = 0; i < IDX_DEPTH; i++) rev_ok[i] = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i && cfg_addr_i == 3'd0) limit = int'(cfg_data_i[9:0]);
      if (req_valid_i && req_ready_i)
        answers_due.push_back(apply_op(req_func_i, req_key_i, req_index_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (answers_due.size() == 0) begin
          report("unexpected beat", '0, '0);
        end else begin
          answer_t w;
          w = answers_due.pop_front();
          if (rsp_status_i !== w.status)
            report("status", 64'(rsp_status_i), 64'(w.status));
          if (rsp_found_i !== w.found)
            report("found", 64'(rsp_found_i), 64'(w.found));
          if (rsp_index_i !== w.index_out)
            report("index_out", 64'(rsp_index_i), 64'(w.index_out));
          if (rsp_key_i !== w.key_out)
            report("key_out", rsp_key_i, w.key_out);
          if (rsp_live_i !== w.live)
            report("live_entries", 64'(rsp_live_i), 64'(w.live));
        end
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lpkim_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   quiet_cycles;
  logic rsp_stall = 1'b0;

  lpkim_req_if req ();
  lpkim_rsp_if rsp ();
  tb_apb_if    apb ();

  // A small key pool makes hits, updates and removes common; a few index
  // values keep the reverse map busy with overwrites.
  logic [63:0] key_pool[24];

  always #4 clk_i = ~clk_i;

  linear_probe_key_index_map dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req.sink),
    .rsp_o   (rsp.source),
    .psel    (apb.psel),
    .penable (apb.penable),
    .pwrite  (apb.pwrite),
    .paddr   (apb.paddr),
    .pwdata  (apb.pwdata),
    .prdata  (apb.prdata),
    .pready  (apb.pready)
  );

  map_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_i (req.ready),
    .req_func_i  (req.func),
    .req_key_i   (req.key),
    .req_index_i (req.index),
    .rsp_valid_i (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_status_i(rsp.status),
    .rsp_found_i (rsp.found),
    .rsp_index_i (rsp.index_out),
    .rsp_key_i   (rsp.key_out),
    .rsp_live_i  (rsp.live_entries),
    .cfg_we_i    (apb.psel && apb.penable && apb.pwrite && apb.pready),
    .cfg_addr_i  (apb.paddr),
    .cfg_data_i  (apb.pwdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    req.valid = 1'b0;
    req.func = F_SET;
    req.key = '0;
    req.index = '0;
    rsp.ready = 1'b0;
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    apb.paddr = '0;
    apb.pwdata = '0;
  end

  // The receiver stalls on its own rhythm: long clean stretches alternate
  // with stretches of random back-pressure.
  always @(posedge clk_i) begin
    rsp_stall <= ($urandom_range(0, 63) < 24) ? 1'($urandom_range(0, 1)) : rsp_stall;
    rsp.ready <= rsp_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Watchdog: nothing accepted for this many cycles ends the run. The
  // clearing pass after reset and the longest remove cascade fit well inside.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic write_limit(input logic [9:0] value);
    apb.psel <= 1'b1;
    apb.pwrite <= 1'b1;
    apb.paddr <= 3'd0;
    apb.pwdata <= {22'd0, value};
    @(posedge clk_i);
    apb.penable <= 1'b1;
    @(posedge clk_i);
    apb.psel <= 1'b0;
    apb.penable <= 1'b0;
    apb.pwrite <= 1'b0;
  endtask

  // Drives one beat and holds it until the block takes it.
  task automatic send_op(input logic [1:0] fn, input logic [63:0] k, input logic [9:0] idx);
    req.valid <= 1'b1;
    req.func <= fn;
    req.key <= k;
    req.index <= idx;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic gap(input int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Lets every outstanding answer arrive, then leaves the block idle a while.
  task automatic drain();
    gap(1);
    while (pending != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pool_key();
    logic [63:0] k;
    case ($urandom_range(0, 9))
      0: begin
        // Fully random key; zero bytes cut it short anywhere.
        k = {$urandom, $urandom};
      end
      1: begin
        // Garbage behind the first zero byte must not matter.
        k = key_pool[$urandom_range(0, 23)];
        k[63:56] = 8'($urandom);
      end
      default: k = key_pool[$urandom_range(0, 23)];
    endcase
    return k;
  endfunction

  // Bursts of well-formed traffic over the key pool, with random gaps.
  task automatic random_phase(input int count);
    int sent;
    int burst;
    logic [1:0] fn;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: fn = F_SET;
          4, 5: fn = F_GET;
          6, 7: fn = F_REMOVE;
          default: fn = F_REVERSE;
        endcase
        send_op(fn, pool_key(),
                ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 31)));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [63:0] k;
    for (int i = 0; i < 24; i++) begin
      k = {$urandom, $urandom};
      // A quarter of the pool keys are three bytes long, one is empty and the rest fill all eight bytes.
      case (i % 4)
        0: k = k & 64'h0000_0000_00FF_FFFF;
        1: k = 64'd0 | (k & 64'h00FF);
        default: ;
      endcase
      for (int b = 0; b < 8; b++) if (k[8*b +: 8] == 8'd0) k[8*b +: 8] = 8'h5A;
      if (i == 5) k = 64'd0;
      if (i == 6) k = 64'hFFFF_FFFF_FFFF_FFFF;
      if (i % 4 == 0) k[63:24] = 40'd0;
      key_pool[i] = k;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation, empty and full-width keys, index extremes.
    send_op(F_REVERSE, 64'd0, 10'd0);
    send_op(F_GET, 64'd0, 10'd0);
    send_op(F_REMOVE, 64'd0, 10'd0);
    send_op(F_SET, 64'd0, 10'd0);
    send_op(F_SET, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023);
    send_op(F_SET, 64'h0000_0000_0000_0041, 10'd5);
    send_op(F_SET, 64'hDEAD_0000_0000_0041, 10'd6);
    send_op(F_GET, 64'h0000_0000_0000_0041, 10'd0);
    send_op(F_REVERSE, 64'd0, 10'd5);
    send_op(F_REVERSE, 64'd0, 10'd6);
    send_op(F_REVERSE, 64'd0, 10'd1023);
    send_op(F_SET, 64'h0000_0000_0000_0042, 10'd1023);
    send_op(F_REVERSE, 64'd0, 10'd1023);
    send_op(F_GET, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
    send_op(F_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
    send_op(F_REVERSE, 64'd0, 10'd1023);
    send_op(F_REMOVE, 64'h7700_0000_0000_0041, 10'd0);
    send_op(F_GET, 64'd0, 10'd0);
    send_op(F_REVERSE, 64'd0, 10'd6);
    drain();

    // Limit of one with live keys left from above: every new insert is refused.
    write_limit(10'd1);
    send_op(F_SET, 64'h0000_0000_0000_0043, 10'd7);
    send_op(F_SET, 64'h0000_0000_0000_0044, 10'd8);
    send_op(F_SET, 64'h0000_0000_0000_0043, 10'd9);
    send_op(F_REMOVE, 64'h0000_0000_0000_0043, 10'd0);
    send_op(F_SET, 64'h0000_0000_0000_0044, 10'd8);
    drain();

    write_limit(10'd0);
    random_phase(60);
    drain();

    write_limit(10'd4);
    random_phase(150);
    drain();

    write_limit(10'd1023);
    random_phase(220);
    drain();

    write_limit(10'd12);
    random_phase(200);

    gap(1);
    while (pending != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lpkim_pkg.sv
rtl/lpkim_if.sv
rtl/lpkim_hash.sv
rtl/linear_probe_key_index_map.sv
sim/tb_channels.sv
sim/map_checker.sv
sim/tb_top.sv
